[rtl/core/hbd_pkg.sv]
package hbd_pkg;

  localparam int unsigned CntW = 32;

  localparam logic [2:0] PH_SIZE = 3'd0;
  localparam logic [2:0] PH_LINE = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_TR1  = 3'd3;
  localparam logic [2:0] PH_TR2  = 3'd4;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd1;
  localparam logic [1:0] MODE_CHUNK = 2'd2;
  localparam logic [1:0] MODE_CLOSE = 2'd3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_LEN  = 1'b1;

  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [2:0]      phase;
    logic [CntW-1:0] remaining;
    logic [CntW-1:0] received;
    logic            fin;
    logic            err;
  } hbd_state_t;

  typedef struct packed {
    logic       pass;
    logic [7:0] data;
    logic       done;
    logic       err;
  } hbd_res_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[rtl/core/hbd_step.sv]
module hbd_step
  import hbd_pkg::*;
(
  input  logic [1:0]      body_mode,
  input  logic [CntW-1:0] content_length,
  input  hbd_state_t      st,
  input  logic            cmd,
  input  logic [7:0]      data_byte,
  output hbd_state_t      st_nxt,
  output hbd_res_t        res
);

  logic            no_body;
  logic [4:0]      hx;
  logic [CntW-1:0] rcv_inc;
  logic [CntW-1:0] rem_dec;
  logic            pass;

  assign no_body = (body_mode == MODE_NONE) ||
                   (body_mode == MODE_FIXED && content_length == '0);
  assign hx      = hex_digit(data_byte);
  assign rcv_inc = st.received + CntW'(1);
  assign rem_dec = st.remaining - CntW'(1);

  always_comb begin
    st_nxt = st;
    pass   = 1'b0;
    if (!(no_body || st.fin)) begin
      if (cmd == CMD_EOS) begin
        st_nxt.fin = 1'b1;
      end else begin
        case (body_mode)
          MODE_FIXED: begin
            pass            = 1'b1;
            st_nxt.received = rcv_inc;
            if (rcv_inc == content_length) begin
              st_nxt.fin = 1'b1;
            end
          end
          MODE_CLOSE: begin
            pass            = 1'b1;
            st_nxt.received = rcv_inc;
          end
          default: begin
            case (st.phase)
              PH_SIZE, PH_LINE: begin
                if (data_byte == CHAR_LF) begin
                  if (st.remaining == '0) begin
                    st_nxt.fin = 1'b1;
                  end else begin
                    st_nxt.phase = PH_DATA;
                  end
                end else if (st.phase == PH_SIZE) begin
                  if (!hx[4]) begin
                    st_nxt.phase = PH_LINE;
                  end else if (st.remaining[CntW-1 -: 4] != 4'd0) begin
                    st_nxt.err       = 1'b1;
                    st_nxt.remaining = '1;
                  end else begin
                    st_nxt.remaining = {st.remaining[CntW-5:0], hx[3:0]};
                  end
                end
              end
              PH_DATA: begin
                pass             = 1'b1;
                st_nxt.received  = rcv_inc;
                st_nxt.remaining = rem_dec;
                if (rem_dec == '0) begin
                  st_nxt.phase = PH_TR1;
                end
              end
              PH_TR1: begin
                st_nxt.phase = PH_TR2;
              end
              default: begin
                st_nxt.phase     = PH_SIZE;
                st_nxt.remaining = '0;
              end
            endcase
          end
        endcase
      end
    end
  end

  assign res.pass = pass;
  assign res.data = pass ? data_byte : 8'd0;
  assign res.done = no_body || st_nxt.fin;
  assign res.err  = st_nxt.err;

endmodule

[rtl/core/http_body_dechunker_unit.sv]
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_cmd, in_data_byte
// out_      output     out_valid / out_ready  out_out_valid, out_byte, out_done_res, out_error
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is accepted every cycle unless the output stalls; each byte passes the input
// register, then the result register; the limit is the single state update between them.
// A stalled result holds the result register, and the input register keeps one more byte.
// Reset and every configuration write return the extraction state to its start.
module http_body_dechunker_unit
  import hbd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_cmd,
  input  logic [7:0]      in_data_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_out_valid,
  output logic [7:0]      out_byte,
  output logic            out_done_res,
  output logic            out_error,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [CntW-1:0] cfg_data
);

  logic            mode_wr;
  logic            len_wr;
  logic [1:0]      body_mode_r;
  logic [CntW-1:0] content_length_r;
  hbd_state_t      st_r;
  hbd_state_t      st_nxt;
  logic            in_vld_r;
  logic            in_cmd_r;
  logic [7:0]      in_byte_r;
  logic            out_vld_r;
  hbd_res_t        res_r;
  hbd_res_t        res_nxt;
  logic            adv;

  assign cfg_ready = 1'b1;
  assign mode_wr   = cfg_valid && cfg_index == CFG_MODE;
  assign len_wr    = cfg_valid && cfg_index == CFG_LEN;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  hbd_step u_step (
    .body_mode      (body_mode_r),
    .content_length (content_length_r),
    .st             (st_r),
    .cmd            (in_cmd_r),
    .data_byte      (in_byte_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r      <= MODE_NONE;
      content_length_r <= '0;
      st_r             <= '0;
      in_vld_r         <= 1'b0;
      out_vld_r        <= 1'b0;
    end else begin
      if (mode_wr) begin
        body_mode_r <= cfg_data[1:0];
      end
      if (len_wr) begin
        content_length_r <= cfg_data;
      end
      if (cfg_valid) begin
        st_r <= '0;
      end else if (adv) begin
        st_r <= st_nxt;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_data_byte;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_out_valid = res_r.pass;
  assign out_byte      = res_r.data;
  assign out_done_res  = res_r.done;
  assign out_error     = res_r.err;

endmodule

[rtl/core/hbd_checker.sv]
module hbd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_out_valid,
  input logic [7:0]      out_byte,
  input logic            out_done_res,
  input logic            cfg_valid,
  input logic            cfg_ready
);

  logic seen_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      seen_done_r <= 1'b0;
    end else if (out_valid && out_ready && out_done_res) begin
      seen_done_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_done_res))
    else $error("result changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_byte == 8'd0)
    else $error("non-body result carries a byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_done_r |-> out_done_res && !out_out_valid)
    else $error("body passed data after completion");

endmodule

bind http_body_dechunker_unit hbd_checker u_hbd_checker (.*);

[tb/http_body_dechunker_unit_tb.sv]
module http_body_dechunker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam string HexChars = "0123456789abcdefABCDEF";

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_cmd = CMD_BYTE;
  logic [7:0]      in_data_byte = 8'h00;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_out_valid;
  logic [7:0]      out_byte;
  logic            out_done_res;
  logic            out_error;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_index = CFG_MODE;
  logic [CntW-1:0] cfg_data = '0;

  // Expected view of the extraction state and its settings.
  logic [1:0]  cur_mode = MODE_NONE;
  logic [31:0] cur_length = 32'd0;
  logic [2:0]  parse_phase = PH_SIZE;
  logic [31:0] chunk_left = 32'd0;
  logic [31:0] body_count = 32'd0;
  logic        body_finished = 1'b0;
  logic        size_overflow = 1'b0;

  hbd_res_t pending_body_results[$];
  int mismatches = 0;
  int sent_items = 0;
  int gap_max = 10;
  int stall_left = 0;
  int cycles = 0;

  http_body_dechunker_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_valid(out_out_valid),
    .out_byte     (out_byte),
    .out_done_res (out_done_res),
    .out_error    (out_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic body_complete();
    if (cur_mode == MODE_NONE) return 1'b1;
    if (cur_mode == MODE_FIXED && cur_length == 32'd0) return 1'b1;
    return body_finished;
  endfunction

  function automatic hbd_res_t next_body_result(input logic cmd, input logic [7:0] c);
    hbd_res_t   r;
    logic       pass;
    logic [4:0] nib;
    pass = 1'b0;
    if (!body_complete()) begin
      if (cmd == CMD_EOS) begin
        body_finished = 1'b1;
      end else if (cur_mode == MODE_FIXED) begin
        pass = 1'b1;
        body_count = body_count + 32'd1;
        if (body_count == cur_length) body_finished = 1'b1;
      end else if (cur_mode == MODE_CLOSE) begin
        pass = 1'b1;
        body_count = body_count + 32'd1;
      end else begin
        case (parse_phase)
          PH_SIZE, PH_LINE: begin
            if (c == CHAR_LF) begin
              if (chunk_left == 32'd0) body_finished = 1'b1;
              else parse_phase = PH_DATA;
            end else if (parse_phase == PH_SIZE) begin
              nib = hex_nibble(c);
              if (!nib[4]) begin
                parse_phase = PH_LINE;
              end else if (chunk_left[31:28] != 4'd0) begin
                size_overflow = 1'b1;
                chunk_left = 32'hFFFF_FFFF;
              end else begin
                chunk_left = {chunk_left[27:0], nib[3:0]};
              end
            end
          end
          PH_DATA: begin
            chunk_left = chunk_left - 32'd1;
            if (chunk_left == 32'd0) parse_phase = PH_TR1;
            pass = 1'b1;
          end
          PH_TR1: begin
            parse_phase = PH_TR2;
          end
          default: begin
            parse_phase = PH_SIZE;
            chunk_left = 32'd0;
          end
        endcase
        if (pass) body_count = body_count + 32'd1;
      end
    end
    r.pass = pass;
    r.data = pass ? c : 8'h00;
    r.done = body_complete();
    r.err = size_overflow;
    return r;
  endfunction

  task automatic send_byte(input logic cmd, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    pending_body_results.push_back(next_body_result(cmd, b));
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(CMD_BYTE, s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CMD_BYTE, ChCr);
    send_byte(CMD_BYTE, CHAR_LF);
  endtask

  task automatic send_random_bytes(input int count);
    repeat (count) send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
  endtask

  // Leaves in_valid low and waits until every transfer has produced its result.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_body_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODE) cur_mode = value[1:0];
    else cur_length = value;
    parse_phase = PH_SIZE;
    chunk_left = 32'd0;
    body_count = 32'd0;
    body_finished = 1'b0;
    size_overflow = 1'b0;
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [31:0] length,
                            input bit with_length);
    logic [31:0] word;
    if (with_length) write_reg(CFG_LEN, length);
    word = $urandom;
    word[1:0] = mode;
    write_reg(CFG_MODE, word);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_idling();
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
  endtask

  function automatic logic [7:0] pick_noise_byte();
    case ($urandom_range(0, 5))
      0, 1: return HexChars[$urandom_range(0, 21)];
      2: return CHAR_LF;
      3: return ChCr;
      4: return ";";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_size_line(input int size);
    string      digits;
    int         i;
    logic [7:0] c;
    digits = $sformatf("%0h", size);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(CMD_BYTE, "0");
    for (i = 0; i < digits.len(); i++) begin
      c = digits[i];
      if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      send_byte(CMD_BYTE, c);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_byte(CMD_BYTE, ";");
      repeat ($urandom_range(0, 4)) begin
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
        send_byte(CMD_BYTE, c);
      end
    end
    if ($urandom_range(0, 4) != 0) send_byte(CMD_BYTE, ChCr);
    send_byte(CMD_BYTE, CHAR_LF);
  endtask

  task automatic test_no_body();
    send_byte(CMD_BYTE, 8'h00);
    send_byte(CMD_EOS, 8'hFF);
    finish_phase();
  endtask

  task automatic test_fixed_length();
    set_config(MODE_FIXED, 32'd0, 1'b1);
    send_byte(CMD_BYTE, 8'hFF);
    finish_phase();
    set_config(MODE_FIXED, 32'd1, 1'b1);
    send_byte(CMD_BYTE, 8'h5A);
    send_byte(CMD_BYTE, 8'hA5);
    finish_phase();
    set_config(MODE_FIXED, 32'hFFFF_FFFF, 1'b1);
    send_byte(CMD_BYTE, 8'hFF);
    send_byte(CMD_EOS, 8'h00);
    finish_phase();
  endtask

  task automatic test_until_close();
    set_config(MODE_CLOSE, 32'd0, 1'b0);
    send_byte(CMD_BYTE, 8'h00);
    send_byte(CMD_BYTE, 8'hFF);
    send_byte(CMD_EOS, 8'h81);
    send_byte(CMD_BYTE, 8'h55);
    finish_phase();
  endtask

  // A size line with no digits, digits after a non-hex byte, an oversized
  // chunk size and a trailer that is not CR LF.
  task automatic test_chunked_directed();
    set_config(MODE_CHUNK, 32'd0, 1'b0);
    send_text("g1\n");
    send_byte(CMD_BYTE, "x");
    finish_phase();
    set_config(MODE_CHUNK, 32'd0, 1'b0);
    send_text("fFfFfFfFa\n");
    send_byte(CMD_BYTE, CHAR_LF);
    send_byte(CMD_EOS, 8'h00);
    finish_phase();
    set_config(MODE_CHUNK, 32'd0, 1'b0);
    send_text("1\nQxy0\n");
    finish_phase();
  endtask

  task automatic test_random_chunked(input int target);
    int size;
    while (sent_items < target) begin
      pick_idling();
      set_config(MODE_CHUNK, $urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
        send_byte(CMD_BYTE, HexChars[$urandom_range(1, 21)]);
        repeat ($urandom_range(8, 11)) send_byte(CMD_BYTE, HexChars[$urandom_range(0, 21)]);
        send_crlf();
        send_random_bytes($urandom_range(0, 6));
        send_byte(CMD_EOS, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 4)) begin
          size = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
          send_size_line(size);
          send_random_bytes(size);
          if ($urandom_range(0, 4) == 0) send_random_bytes(2);
          else send_crlf();
        end
        if ($urandom_range(0, 7) == 0) begin
          send_byte(CMD_EOS, 8'($urandom_range(0, 255)));
        end else begin
          send_size_line(0);
          if ($urandom_range(0, 1) == 1) send_crlf();
        end
      end
      finish_phase();
    end
  endtask

  task automatic test_random_fixed_close(input int target);
    logic [1:0]  mode;
    logic [31:0] length;
    int          pick;
    while (sent_items < target) begin
      pick_idling();
      pick = $urandom_range(0, 9);
      mode = (pick == 0) ? MODE_NONE : (pick < 6) ? MODE_FIXED : MODE_CLOSE;
      pick = $urandom_range(0, 9);
      length = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : (pick == 2) ? 32'd1 :
               (pick == 3) ? 32'h8000_0000 : 32'($urandom_range(2, 40));
      set_config(mode, length, mode == MODE_FIXED || $urandom_range(0, 1) == 1);
      send_random_bytes($urandom_range(0, 45));
      if ($urandom_range(0, 1) == 1) begin
        send_byte(CMD_EOS, 8'($urandom_range(0, 255)));
        send_random_bytes($urandom_range(0, 3));
      end
      finish_phase();
    end
  endtask

  task automatic test_random_noise(input int target);
    while (sent_items < target) begin
      pick_idling();
      set_config(2'($urandom_range(0, 3)), 32'($urandom_range(0, 30)),
                 1'($urandom_range(0, 1)));
      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 39) == 0) send_byte(CMD_EOS, 8'($urandom_range(0, 255)));
        else send_byte(CMD_BYTE, pick_noise_byte());
      end
      finish_phase();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin : check_transfer
      hbd_res_t want;
      hbd_res_t got;
      got = {out_out_valid, out_byte, out_done_res, out_error};
      if (pending_body_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: valid=%0b byte=%02h done=%0b error=%0b",
                   got.pass, got.data, got.done, got.err);
      end else begin
        want = pending_body_results.pop_front();
        if (got.pass !== want.pass || got.data !== want.data ||
            got.done !== want.done || got.err !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected valid=%0b byte=%02h done=%0b error=%0b, got valid=%0b byte=%02h done=%0b error=%0b",
                     want.pass, want.data, want.done, want.err,
                     got.pass, got.data, got.done, got.err);
        end
      end
      stall_left = $urandom_range(0, gap_max);
      out_ready <= (stall_left == 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("http_body_dechunker_unit_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_body();
    test_fixed_length();
    test_until_close();
    test_chunked_directed();
    test_random_chunked(850);
    test_random_fixed_close(1150);
    test_random_noise(1330);
    finish_phase();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_body_results.size() == 0) begin
      $display("http_body_dechunker_unit_tb passed");
    end else begin
      $display("http_body_dechunker_unit_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/hbd_pkg.sv
rtl/core/hbd_step.sv
rtl/core/http_body_dechunker_unit.sv
rtl/core/hbd_checker.sv
tb/http_body_dechunker_unit_tb.sv
